>>> src/fd_pkg.sv
// fd_pkg: shared types and constants for the fall detector
// register indexes, reset levels, config bundle and datapath command word
// no dependencies
package fd_pkg;

   // configuration port geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int LEVEL_W    = 16;
   localparam int STAMP_W    = 32;
   localparam int MAG_OUT_W  = 16;
   localparam int NUM_AXES   = 3;

   // reset values of the level registers
   localparam logic [LEVEL_W-1:0] FREEFALL_RESET = 16'd1024;
   localparam logic [LEVEL_W-1:0] IMPACT_RESET   = 16'd4096;
   localparam logic [LEVEL_W-1:0] SPIN_RESET     = 16'd1879;
   localparam logic [LEVEL_W-1:0] WINDOW_RESET   = 16'd2000;

   // register index, taken from the word address
   typedef enum logic [1:0] {
      REG_FREEFALL = 2'd0,
      REG_IMPACT   = 2'd1,
      REG_SPIN     = 2'd2,
      REG_WINDOW   = 2'd3
   } reg_index_type;

   // axis feeding the shared squarer
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // level registers as seen by the datapath
   typedef struct packed {
      logic [LEVEL_W-1:0] freefall_level;
      logic [LEVEL_W-1:0] impact_level;
      logic [LEVEL_W-1:0] spin_level;
      logic [LEVEL_W-1:0] window_ms;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic     load;
      logic     square;
      axis_type sq_sel;
      logic     accum;
      logic     root_step;
      logic     finish;
   } cmd_type;

endpackage

>>> src/fall_detector.sv
// fall_detector: one word in, magnitude and fall flag out; ingress stalls while busy
// the magnitude comes from the one-bit-per-cycle square root, which runs after
// three passes through the shared squarer
// reset: synchronous, clears the free-fall flag and stamp, levels return to defaults
module fall_detector #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_accel_z,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_rate_x,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_rate_y,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_rate_z,
   input  logic [fd_pkg::STAMP_W-1:0]           req_now_ms,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fd_pkg::MAG_OUT_W-1:0]         rsp_accel_magnitude,
   output logic                                 rsp_fall_detected,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fd_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [fd_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [fd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                 csr_pready
);
   import fd_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   // level registers
   fd_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   fd_ctrl #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic and detection state
   fd_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .accel_x         (req_accel_x),
      .accel_y         (req_accel_y),
      .accel_z         (req_accel_z),
      .rate_x          (req_rate_x),
      .rate_y          (req_rate_y),
      .rate_z          (req_rate_z),
      .now_ms          (req_now_ms),
      .accel_magnitude (rsp_accel_magnitude),
      .fall_detected   (rsp_fall_detected)
   );

   // an accepted word keeps the ingress stalled on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("ingress not stalled after accepting a word");

   // a new result only follows a busy period
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without a word in progress");

   // a new result returns the ingress to ready
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("controller not idle when result raised");

endmodule

>>> src/fd_regs.sv
// fd_regs: APB-style register file holding the four detection levels
// depends on fd_pkg for register indexes, reset values and cfg_type
module fd_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                              csr_pready,
   output fd_pkg::cfg_type                   cfg
);
   import fd_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;
   logic [LEVEL_W-1:0] wr_value;
   logic [LEVEL_W-1:0] rd_value;

   assign index    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en    = csr_psel && csr_penable && csr_pwrite;
   assign wr_value = csr_pwdata[LEVEL_W-1:0];

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_FREEFALL: cfg_in.freefall_level = wr_value;
            REG_IMPACT:   cfg_in.impact_level   = wr_value;
            REG_SPIN:     cfg_in.spin_level     = wr_value;
            REG_WINDOW:   cfg_in.window_ms      = wr_value;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freefall_level <= FREEFALL_RESET;
         cfg_ff.impact_level   <= IMPACT_RESET;
         cfg_ff.spin_level     <= SPIN_RESET;
         cfg_ff.window_ms      <= WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         REG_FREEFALL: rd_value = cfg_ff.freefall_level;
         REG_IMPACT:   rd_value = cfg_ff.impact_level;
         REG_SPIN:     rd_value = cfg_ff.spin_level;
         REG_WINDOW:   rd_value = cfg_ff.window_ms;
         default:      rd_value = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_W'(rd_value);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

>>> src/fd_ctrl.sv
// fd_ctrl: sequencer for one word: capture, square and sum, root steps, decide
// depends on fd_pkg for cmd_type and axis_type
module fd_ctrl #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output fd_pkg::cmd_type cmd
);
   import fd_pkg::*;

   localparam int CW = $clog2(SAMPLE_WIDTH + 1);
   localparam logic [CW-1:0] SQ_LAST   = CW'(NUM_AXES);
   localparam logic [CW-1:0] ROOT_LAST = CW'(SAMPLE_WIDTH - 1);

   typedef enum logic [1:0] {
      IDLE,
      SQUARE,
      ROOT,
      DECIDE
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          req_stall_ff, req_stall_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.sq_sel    = AXIS_X;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = SQUARE;
            end
         end
         SQUARE: begin
            // squarer runs on the first three counts, adder accumulates on the last three
            cmd.square = (cnt_ff < SQ_LAST);
            cmd.accum  = (cnt_ff != '0);
            case (cnt_ff[1:0])
               2'd0:    cmd.sq_sel = AXIS_X;
               2'd1:    cmd.sq_sel = AXIS_Y;
               2'd2:    cmd.sq_sel = AXIS_Z;
               default: cmd.sq_sel = AXIS_X;
            endcase
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = ROOT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = DECIDE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         DECIDE: begin
            // state update and result write happen together once the slot is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      req_stall_in = (state_in != IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         req_stall_ff <= req_stall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/fd_datapath.sv
// fd_datapath: abs values, shared squarer, bit-serial root and fall decision
// depends on fd_pkg for cfg_type, cmd_type and axis_type
module fd_datapath #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fd_pkg::cmd_type                      cmd,
   input  fd_pkg::cfg_type                      cfg,
   input  logic signed [SAMPLE_WIDTH-1:0]       accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0]       accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0]       accel_z,
   input  logic signed [SAMPLE_WIDTH-1:0]       rate_x,
   input  logic signed [SAMPLE_WIDTH-1:0]       rate_y,
   input  logic signed [SAMPLE_WIDTH-1:0]       rate_z,
   input  logic [fd_pkg::STAMP_W-1:0]           now_ms,
   output logic [fd_pkg::MAG_OUT_W-1:0]         accel_magnitude,
   output logic                                 fall_detected
);
   import fd_pkg::*;

   localparam int W  = SAMPLE_WIDTH;
   localparam int NW = 2 * SAMPLE_WIDTH;
   localparam int LW = (SAMPLE_WIDTH > LEVEL_W) ? SAMPLE_WIDTH : LEVEL_W;

   function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
      logic [W-1:0] r;
      r = v[W-1] ? (~v + W'(1)) : v;
      return r;
   endfunction

   // captured word
   logic [W-1:0]       ax_ff, ay_ff, az_ff;
   logic [STAMP_W-1:0] now_ff;
   logic               spin_ff;
   logic               spin_in;

   // square and root
   logic [W-1:0]  mul_a;
   logic [NW-1:0] prod_ff;
   logic [NW-1:0] sum_ff;
   logic [W-1:0]  rem_ff;
   logic [W-1:0]  root_ff;
   logic [W+1:0]  rem_sh;
   logic [W+1:0]  trial;
   logic          take;

   // decision
   logic               armed_ff, armed_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [LW-1:0]      mag_x;
   logic               arm_new;
   logic               armed_mid;
   logic [STAMP_W-1:0] elapsed;
   logic               fall_in;
   logic [MAG_OUT_W-1:0] mag_out_ff;
   logic               fall_out_ff;

   // any rate beyond the spin level, judged at capture
   always_comb begin
      logic [LW-1:0] spin_lvl;
      spin_lvl = LW'(cfg.spin_level);
      spin_in  = (LW'(abs_w(rate_x)) > spin_lvl) ||
                 (LW'(abs_w(rate_y)) > spin_lvl) ||
                 (LW'(abs_w(rate_z)) > spin_lvl);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff   <= abs_w(accel_x);
         ay_ff   <= abs_w(accel_y);
         az_ff   <= abs_w(accel_z);
         now_ff  <= now_ms;
         spin_ff <= spin_in;
      end
   end

   // shared squarer
   always_comb begin
      case (cmd.sq_sel)
         AXIS_X:  mul_a = ax_ff;
         AXIS_Y:  mul_a = ay_ff;
         AXIS_Z:  mul_a = az_ff;
         default: mul_a = ax_ff;
      endcase
   end

   // one root bit per step, radicand shifted out two bits at a time
   // the remainder stays below 2^W until the last step
   assign rem_sh = {rem_ff, sum_ff[NW-1:NW-2]};
   assign trial  = {root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         prod_ff <= NW'(mul_a) * NW'(mul_a);
      end
      if (cmd.load) begin
         sum_ff  <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.accum) begin
         sum_ff <= sum_ff + prod_ff;
      end else if (cmd.root_step) begin
         sum_ff  <= {sum_ff[NW-3:0], 2'b00};
         rem_ff  <= take ? W'(rem_sh - trial) : W'(rem_sh);
         root_ff <= {root_ff[W-2:0], take};
      end
   end

   // free-fall arming, window expiry, then impact test
   always_comb begin
      mag_x     = LW'(root_ff);
      arm_new   = (mag_x < LW'(cfg.freefall_level));
      stamp_in  = arm_new ? now_ff : stamp_ff;
      elapsed   = now_ff - stamp_in;
      armed_mid = (armed_ff || arm_new) && !(elapsed > STAMP_W'(cfg.window_ms));
      fall_in   = (mag_x > LW'(cfg.impact_level)) && (spin_ff || armed_mid);
      armed_in  = armed_mid && !fall_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         stamp_ff <= '0;
      end else if (cmd.finish) begin
         armed_ff <= armed_in;
         stamp_ff <= stamp_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         mag_out_ff  <= mag_x[MAG_OUT_W-1:0];
         fall_out_ff <= fall_in;
      end
   end

   assign accel_magnitude = mag_out_ff;
   assign fall_detected   = fall_out_ff;

endmodule
